/* rtl/core/nfha_pkg.sv */
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared types and constants of the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam int REGION_BYTES = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int OFF_W        = 12;
	localparam int SIZE_W       = 13;
	localparam int ADDR_W       = $clog2(REGION_BYTES);

	localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] REGION_SZ = SIZE_W'(REGION_BYTES);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic              used;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  next;
		logic              has_next;
	} hdr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		hdr_t              wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DEC,
		FSM_AWALK,
		FSM_AHEAD,
		FSM_FWALK,
		FSM_FMRG,
		FSM_DONE
	} fsm_t;

endpackage

/* rtl/core/nfha_hdr_ram.sv */
// ----------------------------------------------------------------------------
// nfha_hdr_ram
// Header store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nfha_hdr_ram (
	input  logic               clk,
	input  nfha_pkg::mem_req_t req,
	output nfha_pkg::hdr_t     rdata
);

	nfha_pkg::hdr_t mem [nfha_pkg::REGION_BYTES];
	nfha_pkg::hdr_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/nfha_ctrl.sv */
// ----------------------------------------------------------------------------
// nfha_ctrl
// Command sequencer: walks the block chain in the header store, one hop a
// cycle, and writes back split or merged headers.
// ----------------------------------------------------------------------------
module nfha_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    cmd,
	input  logic [nfha_pkg::SIZE_W-1:0]   req_size,
	input  logic [nfha_pkg::OFF_W-1:0]    payload_offset,
	input  logic [nfha_pkg::SIZE_W-1:0]   region_size,
	input  logic                          take,
	output logic                          idle,
	output logic                          done,
	output logic [1:0]                    res_status,
	output logic [nfha_pkg::OFF_W-1:0]    res_offset,
	output nfha_pkg::mem_req_t            mreq,
	input  nfha_pkg::hdr_t                rdata
);

	localparam int SW = nfha_pkg::SIZE_W;
	localparam int OW = nfha_pkg::OFF_W;

	nfha_pkg::fsm_t state_q, state_d;

	logic [1:0]    cmd_q, cmd_d;
	logic [SW-1:0] need_q, need_d;
	logic [OW-1:0] pay_q, pay_d;
	logic [OW-1:0] cur_q, cur_d;
	logic [OW-1:0] prev_q, prev_d;
	logic [OW-1:0] rover_q, rover_d;
	logic          ready_q, ready_d;
	logic          phase_q, phase_d;
	logic          have_prev_q, have_prev_d;
	nfha_pkg::hdr_t prev_hdr_q, prev_hdr_d;
	nfha_pkg::hdr_t c_hdr_q, c_hdr_d;
	logic [1:0]    status_q, status_d;
	logic [OW-1:0] off_q, off_d;

	logic [SW:0]   need_hdr;
	logic [SW:0]   nb_wide;
	logic [SW-1:0] rs;
	logic          fit;
	logic          split;
	logic          merged_prev;
	logic          nx_free;
	logic [SW:0]   msize;
	logic [OW-1:0] cur_pay;

	assign rs       = (region_size > nfha_pkg::REGION_SZ) ? nfha_pkg::REGION_SZ : region_size;
	assign need_hdr = {1'b0, need_q} + {1'b0, nfha_pkg::HDR_SZ};
	assign nb_wide  = {2'b00, cur_q} + need_hdr;
	assign fit      = !rdata.used && (rdata.size >= need_q);
	assign split    = ({1'b0, rdata.size} > need_hdr) && (nb_wide < {1'b0, nfha_pkg::REGION_SZ});
	assign cur_pay  = cur_q + OW'(nfha_pkg::HEADER_BYTES);
	assign merged_prev = have_prev_q && !prev_hdr_q.used;
	assign nx_free  = c_hdr_q.has_next && !rdata.used;

	always_comb begin
		msize = merged_prev
			? ({1'b0, prev_hdr_q.size} + {1'b0, c_hdr_q.size} + {1'b0, nfha_pkg::HDR_SZ})
			: {1'b0, c_hdr_q.size};
		if (nx_free) begin
			msize = msize + {1'b0, rdata.size} + {1'b0, nfha_pkg::HDR_SZ};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nfha_pkg::FSM_IDLE;
			rover_q     <= '0;
			ready_q     <= 1'b0;
			phase_q     <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rover_q     <= rover_d;
			ready_q     <= ready_d;
			phase_q     <= phase_d;
			have_prev_q <= have_prev_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		need_q     <= need_d;
		pay_q      <= pay_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		prev_hdr_q <= prev_hdr_d;
		c_hdr_q    <= c_hdr_d;
		status_q   <= status_d;
		off_q      <= off_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		need_d      = need_q;
		pay_d       = pay_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		rover_d     = rover_q;
		ready_d     = ready_q;
		phase_d     = phase_q;
		have_prev_d = have_prev_q;
		prev_hdr_d  = prev_hdr_q;
		c_hdr_d     = c_hdr_q;
		status_d    = status_q;
		off_d       = off_q;
		mreq        = '0;

		unique case (state_q)
			nfha_pkg::FSM_IDLE: begin
				if (start) begin
					cmd_d   = cmd;
					need_d  = req_size;
					pay_d   = payload_offset;
					state_d = nfha_pkg::FSM_DEC;
				end
			end
			nfha_pkg::FSM_DEC: begin
				off_d   = '0;
				state_d = nfha_pkg::FSM_DONE;
				unique case (cmd_q)
					nfha_pkg::CMD_ALLOC: begin
						if (!ready_q || need_q == '0) begin
							status_d = nfha_pkg::ST_FAIL;
						end else begin
							mreq.re    = 1'b1;
							mreq.raddr = rover_q;
							cur_d      = rover_q;
							phase_d    = 1'b0;
							state_d    = nfha_pkg::FSM_AWALK;
						end
					end
					nfha_pkg::CMD_FREE: begin
						if (!ready_q) begin
							status_d = nfha_pkg::ST_FAIL;
						end else if (pay_q == '0) begin
							status_d = nfha_pkg::ST_BAD;
						end else begin
							mreq.re     = 1'b1;
							mreq.raddr  = '0;
							cur_d       = '0;
							have_prev_d = 1'b0;
							state_d     = nfha_pkg::FSM_FWALK;
						end
					end
					nfha_pkg::CMD_INIT: begin
						if (rs <= nfha_pkg::HDR_SZ) begin
							status_d = nfha_pkg::ST_FAIL;
						end else begin
							mreq.we    = 1'b1;
							mreq.waddr = '0;
							mreq.wdata = '{used: 1'b0, size: rs - nfha_pkg::HDR_SZ,
								next: '0, has_next: 1'b0};
							rover_d    = '0;
							ready_d    = 1'b1;
							status_d   = nfha_pkg::ST_OK;
						end
					end
					default: status_d = nfha_pkg::ST_BAD;
				endcase
			end
			nfha_pkg::FSM_AWALK: begin
				priority if (fit) begin
					if (split) begin
						// write the remainder first, then the chosen header
						mreq.we    = 1'b1;
						mreq.waddr = nb_wide[OW-1:0];
						mreq.wdata = '{used: 1'b0,
							size: SW'({1'b0, rdata.size} - need_hdr),
							next: rdata.next, has_next: rdata.has_next};
						state_d    = nfha_pkg::FSM_AHEAD;
					end else begin
						mreq.we    = 1'b1;
						mreq.waddr = cur_q;
						mreq.wdata = '{used: 1'b1, size: rdata.size,
							next: rdata.next, has_next: rdata.has_next};
						rover_d    = cur_q;
						status_d   = nfha_pkg::ST_OK;
						off_d      = cur_pay;
						state_d    = nfha_pkg::FSM_DONE;
					end
				end else if (!rdata.has_next) begin
					if (!phase_q && rover_q != '0) begin
						// wrap to the start of the chain
						mreq.re    = 1'b1;
						mreq.raddr = '0;
						cur_d      = '0;
						phase_d    = 1'b1;
					end else begin
						status_d = nfha_pkg::ST_FAIL;
						off_d    = '0;
						state_d  = nfha_pkg::FSM_DONE;
					end
				end else if (phase_q && rdata.next == rover_q) begin
					status_d = nfha_pkg::ST_FAIL;
					off_d    = '0;
					state_d  = nfha_pkg::FSM_DONE;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = rdata.next;
					cur_d      = rdata.next;
				end
			end
			nfha_pkg::FSM_AHEAD: begin
				mreq.we    = 1'b1;
				mreq.waddr = cur_q;
				mreq.wdata = '{used: 1'b1, size: need_q, next: nb_wide[OW-1:0], has_next: 1'b1};
				rover_d    = cur_q;
				status_d   = nfha_pkg::ST_OK;
				off_d      = cur_pay;
				state_d    = nfha_pkg::FSM_DONE;
			end
			nfha_pkg::FSM_FWALK: begin
				priority if ({1'b0, cur_q} + SW'(nfha_pkg::HEADER_BYTES) == {1'b0, pay_q}) begin
					if (!rdata.used) begin
						status_d = nfha_pkg::ST_BAD;
						state_d  = nfha_pkg::FSM_DONE;
					end else begin
						c_hdr_d = rdata;
						if (rover_q == cur_q) begin
							rover_d = '0;
						end
						mreq.re    = rdata.has_next;
						mreq.raddr = rdata.next;
						state_d    = nfha_pkg::FSM_FMRG;
					end
				end else if (!rdata.has_next) begin
					status_d = nfha_pkg::ST_BAD;
					state_d  = nfha_pkg::FSM_DONE;
				end else begin
					prev_d      = cur_q;
					prev_hdr_d  = rdata;
					have_prev_d = 1'b1;
					cur_d       = rdata.next;
					mreq.re     = 1'b1;
					mreq.raddr  = rdata.next;
				end
			end
			nfha_pkg::FSM_FMRG: begin
				mreq.we    = 1'b1;
				mreq.waddr = merged_prev ? prev_q : cur_q;
				mreq.wdata = '{used: 1'b0, size: msize[SW-1:0],
					next: nx_free ? rdata.next : c_hdr_q.next,
					has_next: nx_free ? rdata.has_next : c_hdr_q.has_next};
				// move the rover onto the merged block if its block is absorbed
				if (nx_free && rover_q == c_hdr_q.next) begin
					rover_d = merged_prev ? prev_q : cur_q;
				end
				status_d = nfha_pkg::ST_OK;
				state_d  = nfha_pkg::FSM_DONE;
			end
			nfha_pkg::FSM_DONE: begin
				if (take) begin
					state_d = nfha_pkg::FSM_IDLE;
				end
			end
			default: state_d = nfha_pkg::FSM_IDLE;
		endcase
	end

	assign idle       = (state_q == nfha_pkg::FSM_IDLE);
	assign done       = (state_q == nfha_pkg::FSM_DONE);
	assign res_status = status_q;
	assign res_offset = off_q;

endmodule

/* rtl/core/next_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit allocator over a byte region with headers chained in a memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command beat: cmd,
// req_size, payload_offset. Output channel (out_valid / out_stall) carries
// one result beat per command: status, result_offset.
// region_size is to be written through cfg_we / cfg_wdata only while the
// block is idle, which the block itself does not enforce; it takes effect
// at the next init command.
// Allocate visits headers from the rover on; free walks the chain from its
// start. Each visited header costs one read of the header memory, which sets
// the rate; one command is in work at a time.
// Reset clears the rover and the ready flag: allocate and free fail until
// an init succeeds. The header memory itself is not cleared.
// When the receiver stalls, the result waits in the output register; the
// next command may start meanwhile and holds its own result until the
// register frees up.
module next_fit_heap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [nfha_pkg::SIZE_W-1:0]   req_size,
	input  logic [nfha_pkg::OFF_W-1:0]    payload_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [nfha_pkg::OFF_W-1:0]    result_offset,
	input  logic                          cfg_we,
	input  logic [nfha_pkg::SIZE_W-1:0]   cfg_wdata
);

	logic [nfha_pkg::SIZE_W-1:0] region_size_q;
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [nfha_pkg::OFF_W-1:0]  offset_q;

	logic                        idle;
	logic                        done;
	logic                        take;
	logic [1:0]                  res_status;
	logic [nfha_pkg::OFF_W-1:0]  res_offset;
	nfha_pkg::mem_req_t          mreq;
	nfha_pkg::hdr_t              rdata;

	assign take     = done && (!out_valid_q || !out_stall);
	assign in_stall = !idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_size_q <= nfha_pkg::REGION_SZ;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				region_size_q <= cfg_wdata;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= res_status;
			offset_q <= res_offset;
		end
	end

	nfha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_valid && idle),
		.cmd            (cmd),
		.req_size       (req_size),
		.payload_offset (payload_offset),
		.region_size    (region_size_q),
		.take           (take),
		.idle           (idle),
		.done           (done),
		.res_status     (res_status),
		.res_offset     (res_offset),
		.mreq           (mreq),
		.rdata          (rdata)
	);

	nfha_hdr_ram u_ram (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_offset = offset_q;

endmodule
